### src/ilid_pkg.sv
`default_nettype none

package ilid_pkg;

    localparam int CAPACITY   = 256;
    localparam int IDX_W      = $clog2(CAPACITY);
    localparam int LEN_W      = $clog2(CAPACITY + 1);
    localparam int DATA_W     = 32;
    localparam int POS_W      = 11;
    localparam int REQ_W      = 3;
    localparam int CMP_W      = 16;
    localparam int GROUP      = 16;
    localparam int NUM_GROUPS = (CAPACITY + GROUP - 1) / GROUP;
    localparam int S_DATA_W   = 48;
    localparam int M_DATA_W   = 48;

    typedef enum logic [REQ_W-1:0] {
        REQ_READ       = 3'd0,
        REQ_INS_HEAD   = 3'd1,
        REQ_INS_TAIL   = 3'd2,
        REQ_INS_AT     = 3'd3,
        REQ_DELETE     = 3'd4
    } t_req;

    typedef enum logic [1:0] {
        CELL_HOLD = 2'd0,
        CELL_INS  = 2'd1,
        CELL_DEL  = 2'd2
    } t_cell_op;

    typedef struct packed {
        t_cell_op          op;
        logic [IDX_W-1:0]  pos;
        logic [DATA_W-1:0] value;
    } t_cell_ctl;

endpackage

`default_nettype wire

### src/ilid_cell.sv
`default_nettype none

module ilid_cell
    import ilid_pkg::*;
(
    input  wire logic              i_clk,
    input  wire t_cell_ctl         i_ctl,
    input  wire logic [IDX_W-1:0]  i_idx,
    input  wire logic [DATA_W-1:0] i_left,
    input  wire logic [DATA_W-1:0] i_right,
    output logic      [DATA_W-1:0] o_value,
    output logic      [DATA_W-1:0] o_rd
);

    logic [DATA_W-1:0] r_value;

    always_ff @(posedge i_clk) begin
        unique case (i_ctl.op)
            CELL_INS: begin
                if (i_idx > i_ctl.pos) begin
                    r_value <= i_left;
                end else if (i_idx == i_ctl.pos) begin
                    r_value <= i_ctl.value;
                end
            end
            CELL_DEL: begin
                if (i_idx >= i_ctl.pos) begin
                    r_value <= i_right;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_value = r_value;
    // masked for the read OR tree
    assign o_rd    = (i_idx == i_ctl.pos) ? r_value : '0;

endmodule

`default_nettype wire

### src/indexed_list_insert_delete_top.sv
// Indexed list: an ordered list of up to 256 signed 32-bit values kept in a
// row of shift cells, one value per cell.
// Input channel (s_axis): one request item per handshake, tdata holds
// req_type [2:0], position [13:3] (signed), item_value [45:14].
// Output channel (m_axis): one result item per request, tdata holds
// read_value [31:0], ok [32], list_length [41:33].
// Inserts and deletes shift all cells at or above the index in the cycle the
// item is accepted. Reads select the cell through a two-level OR tree, one
// level registered, which sets the rate.
// No new item is taken while an accepted one has not yet moved into the
// output register; the next item is accepted as soon as the previous one has
// moved into the output register, even while that result waits.
// Receiver stall: the output register holds; at most one further item is
// accepted and then waits until the output register frees.
// Reset (synchronous, active low) empties the list; cell contents are not
// cleared, only cells below the length are ever read.
`default_nettype none

module indexed_list_insert_delete_top
    import ilid_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_s_axis_tvalid,
    output logic                     o_s_axis_tready,
    // req_type[2:0], position[13:3], item_value[45:14], zero pad
    input  wire logic [S_DATA_W-1:0] i_s_axis_tdata,
    output logic                     o_m_axis_tvalid,
    input  wire logic                i_m_axis_tready,
    // read_value[31:0], ok[32], list_length[41:33], zero pad
    output logic      [M_DATA_W-1:0] o_m_axis_tdata
);

    logic [REQ_W-1:0]  w_req;
    logic [POS_W-1:0]  w_pos;
    logic [DATA_W-1:0] w_val;
    logic              w_acc;
    logic [CMP_W-1:0]  w_pos_c;
    logic [CMP_W-1:0]  w_len_c;
    logic              w_in_range;
    logic              w_not_full;
    logic              w_ins_ok;
    logic [CMP_W-1:0]  w_ins_pos;
    t_cell_ctl         w_ctl;
    logic              w_ok;
    logic [LEN_W-1:0]  n_len;

    logic [DATA_W-1:0] w_cell_val [CAPACITY];
    logic [DATA_W-1:0] w_cell_rd  [CAPACITY];
    logic [DATA_W-1:0] n_grp      [NUM_GROUPS];
    logic [DATA_W-1:0] w_rd_sum;
    logic [DATA_W-1:0] w_rd_out;

    logic              r_busy;
    logic [LEN_W-1:0]  r_len;
    logic              r_is_read;
    logic              r_miss;
    logic              r_ok;
    logic [DATA_W-1:0] r_grp [NUM_GROUPS];
    logic              r_m_valid;
    logic [M_DATA_W-1:0] r_m_data;

    assign w_req = i_s_axis_tdata[REQ_W-1:0];
    assign w_pos = i_s_axis_tdata[REQ_W +: POS_W];
    assign w_val = i_s_axis_tdata[REQ_W+POS_W +: DATA_W];

    assign o_s_axis_tready = !r_busy;
    assign w_acc           = i_s_axis_tvalid && !r_busy;

    assign w_pos_c    = w_pos[POS_W-1] ? '0 : CMP_W'(w_pos[POS_W-2:0]);
    assign w_len_c    = CMP_W'(r_len);
    assign w_in_range = !w_pos[POS_W-1] && (w_pos_c < w_len_c);
    assign w_not_full = (w_len_c < CMP_W'(CAPACITY));

    always_comb begin
        w_ctl       = '{op: CELL_HOLD, pos: w_pos_c[IDX_W-1:0], value: w_val};
        w_ins_ok    = 1'b0;
        w_ins_pos   = '0;
        w_ok        = 1'b0;
        n_len       = r_len;
        unique case (w_req)
            REQ_READ: begin
                w_ok = w_in_range;
            end
            REQ_INS_HEAD: begin
                w_ins_ok  = w_not_full;
                w_ins_pos = '0;
            end
            REQ_INS_TAIL: begin
                w_ins_ok  = w_not_full;
                w_ins_pos = w_len_c;
            end
            REQ_INS_AT: begin
                w_ins_ok  = w_not_full && (w_pos_c <= w_len_c);
                w_ins_pos = w_pos_c;
            end
            REQ_DELETE: begin
                w_ok = w_in_range;
                if (w_in_range) begin
                    w_ctl.op = CELL_DEL;
                    n_len    = r_len - LEN_W'(1);
                end
            end
            default: begin
            end
        endcase
        if (w_ins_ok) begin
            w_ok      = 1'b1;
            w_ctl.op  = CELL_INS;
            w_ctl.pos = w_ins_pos[IDX_W-1:0];
            n_len     = r_len + LEN_W'(1);
        end
        if (!w_acc) begin
            w_ctl.op = CELL_HOLD;
        end
    end

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [DATA_W-1:0] w_left;
        logic [DATA_W-1:0] w_right;
        if (i == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_cell_val[i-1];
        end
        if (i == CAPACITY - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_mid_r
            assign w_right = w_cell_val[i+1];
        end
        ilid_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_idx   (IDX_W'(i)),
            .i_left  (w_left),
            .i_right (w_right),
            .o_value (w_cell_val[i]),
            .o_rd    (w_cell_rd[i])
        );
    end

    always_comb begin
        for (int g = 0; g < NUM_GROUPS; g++) begin
            n_grp[g] = '0;
            for (int k = 0; k < GROUP; k++) begin
                if (g * GROUP + k < CAPACITY) begin
                    n_grp[g] = n_grp[g] | w_cell_rd[g * GROUP + k];
                end
            end
        end
    end

    always_comb begin
        w_rd_sum = '0;
        for (int g = 0; g < NUM_GROUPS; g++) begin
            w_rd_sum = w_rd_sum | r_grp[g];
        end
        if (!r_is_read) begin
            w_rd_out = '0;
        end else if (r_miss) begin
            w_rd_out = '1;
        end else begin
            w_rd_out = w_rd_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_is_read <= (w_req == REQ_READ);
            r_miss    <= !w_in_range;
            r_ok      <= w_ok;
            r_grp     <= n_grp;
        end
        if (r_busy && (!r_m_valid || i_m_axis_tready)) begin
            r_m_data <= {(M_DATA_W - DATA_W - 1 - LEN_W)'(0), r_len, r_ok, w_rd_out};
        end
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_len     <= '0;
            r_m_valid <= 1'b0;
        end else begin
            if (w_acc) begin
                r_busy <= 1'b1;
                r_len  <= n_len;
            end else if (r_busy && (!r_m_valid || i_m_axis_tready)) begin
                r_busy <= 1'b0;
            end
            if (r_busy && (!r_m_valid || i_m_axis_tready)) begin
                r_m_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_data;

`ifndef SYNTHESIS
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CMP_W'(r_len) <= CMP_W'(CAPACITY))
        else $error("list length above capacity");

    a_acc_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |=> r_busy)
        else $error("accepted item not held");

    a_len_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_acc |=> $stable(r_len))
        else $error("length changed without an item");
`endif

endmodule

`default_nettype wire

### tb/indexed_list_insert_delete_top_tb.sv
`timescale 1ns / 1ps

module indexed_list_insert_delete_top_tb;
    import ilid_pkg::*;

    localparam logic [REQ_W-1:0] REQ_BAD_FIRST = 3'd5;
    localparam logic [REQ_W-1:0] REQ_BAD_LAST  = 3'd7;
    localparam logic [DATA_W-1:0] VAL_MIN = 32'h8000_0000;
    localparam logic [DATA_W-1:0] VAL_MAX = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] VAL_NEG1 = 32'hFFFF_FFFF;
    localparam int POS_MIN = -1024;
    localparam int POS_MAX = 1023;

    typedef struct {
        logic [DATA_W-1:0] rd;
        logic              ok;
        logic [8:0]        len;
    } t_list_result;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                s_tvalid = 1'b0;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic                m_tready = 1'b1;
    logic                o_s_axis_tready;
    logic                o_m_axis_tvalid;
    logic [M_DATA_W-1:0] o_m_axis_tdata;

    // shadow copy of the list
    logic [DATA_W-1:0] list_mem [CAPACITY];
    int                list_len = 0;

    t_list_result result_q[$];
    int  fails = 0;
    int  n_sent = 0;
    int  n_checked = 0;
    int  n_full_refused = 0;
    int  peak_len = 0;
    int  rx_hold = 0;
    bit  no_idle = 1'b0;

    always #4 i_clk = ~i_clk;

    indexed_list_insert_delete_top u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    function automatic void list_insert(int p, logic [DATA_W-1:0] v);
        for (int i = list_len; i > p; i--)
            list_mem[i] = list_mem[i-1];
        list_mem[p] = v;
        list_len++;
        if (list_len > peak_len)
            peak_len = list_len;
    endfunction

    function automatic t_list_result list_apply(logic [REQ_W-1:0] req,
                                                logic signed [POS_W-1:0] pos,
                                                logic [DATA_W-1:0] val);
        t_list_result r;
        int p;
        p = int'(pos);
        r.rd = '0;
        r.ok = 1'b0;
        case (req)
            REQ_READ: begin
                if (p >= 0 && p < list_len) begin
                    r.rd = list_mem[p];
                    r.ok = 1'b1;
                end else begin
                    r.rd = VAL_NEG1;
                end
            end
            REQ_INS_HEAD, REQ_INS_TAIL, REQ_INS_AT: begin
                if (req == REQ_INS_HEAD)
                    p = 0;
                else if (req == REQ_INS_TAIL)
                    p = list_len;
                else if (p < 0)
                    p = 0;
                if (list_len >= CAPACITY) begin
                    if (p <= list_len)
                        n_full_refused++;
                end else if (p <= list_len) begin
                    list_insert(p, val);
                    r.ok = 1'b1;
                end
            end
            REQ_DELETE: begin
                if (p >= 0 && p < list_len) begin
                    for (int i = p; i + 1 < list_len; i++)
                        list_mem[i] = list_mem[i+1];
                    list_len--;
                    r.ok = 1'b1;
                end
            end
            default: ;
        endcase
        r.len = list_len[8:0];
        return r;
    endfunction

    task automatic send_req(input logic [REQ_W-1:0] req, input int pos,
                            input logic [DATA_W-1:0] val);
        int gap;
        logic signed [POS_W-1:0] p;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        p = POS_W'(pos);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, val, p, req};
        result_q.push_back(list_apply(req, p, val));
        do @(posedge i_clk); while (!o_s_axis_tready);
        n_sent++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (result_q.size() != 0)
            @(posedge i_clk);
    endtask

    function automatic logic [DATA_W-1:0] rand_value();
        case ($urandom_range(0, 15))
            0: return VAL_MIN;
            1: return VAL_MAX;
            2: return VAL_NEG1;
            3: return '0;
            default: return $urandom;
        endcase
    endfunction

    // result side: check each item, then a random stall
    always @(posedge i_clk) begin : rx_side
        t_list_result want;
        logic [DATA_W-1:0] got_rd;
        logic got_ok;
        logic [8:0] got_len;
        int stall;
        if (i_rst_n) begin
            if (rx_hold > 0) begin
                rx_hold <= rx_hold - 1;
                if (rx_hold == 1)
                    m_tready <= 1'b1;
            end else if (o_m_axis_tvalid && m_tready) begin
                got_rd  = o_m_axis_tdata[31:0];
                got_ok  = o_m_axis_tdata[32];
                got_len = o_m_axis_tdata[41:33];
                if (result_q.size() == 0) begin
                    $error("result item with no request pending");
                    fails++;
                end else begin
                    want = result_q.pop_front();
                    n_checked++;
                    if (got_rd !== want.rd) begin
                        $error("read_value: expected %0d, got %0d",
                               $signed(want.rd), $signed(got_rd));
                        fails++;
                    end
                    if (got_ok !== want.ok) begin
                        $error("ok: expected %0d, got %0d", want.ok, got_ok);
                        fails++;
                    end
                    if (got_len !== want.len) begin
                        $error("list_length: expected %0d, got %0d", want.len, got_len);
                        fails++;
                    end
                end
                stall = no_idle ? 0 : $urandom_range(0, 3);
                if (stall > 0) begin
                    m_tready <= 1'b0;
                    rx_hold  <= stall;
                end
            end
        end
    end

    task automatic test_empty_list();
        send_req(REQ_READ, 0, '0);
        send_req(REQ_READ, -1, '0);
        send_req(REQ_READ, POS_MAX, '0);
        send_req(REQ_READ, POS_MIN, '0);
        send_req(REQ_DELETE, 0, '0);
        send_req(REQ_DELETE, -1, '0);
        send_req(REQ_INS_AT, 1, VAL_MAX);
        for (int r = int'(REQ_BAD_FIRST); r <= int'(REQ_BAD_LAST); r++)
            send_req(r[REQ_W-1:0], 0, VAL_NEG1);
    endtask

    task automatic test_basic_ops();
        send_req(REQ_INS_HEAD, 0, VAL_MAX);
        send_req(REQ_INS_TAIL, POS_MIN, VAL_MIN);
        send_req(REQ_INS_AT, 1, VAL_NEG1);
        send_req(REQ_INS_AT, -1, '0);
        send_req(REQ_INS_AT, POS_MIN, 32'h1234_5678);
        send_req(REQ_INS_AT, list_len, 32'hA5A5_5A5A);
        send_req(REQ_INS_AT, list_len + 1, 32'h5A5A_A5A5);
        send_req(REQ_INS_AT, POS_MAX, 32'h0F0F_0F0F);
        for (int i = 0; i < list_len; i++)
            send_req(REQ_READ, i, '0);
        send_req(REQ_READ, list_len, '0);
        // hold off until the list has answered everything
        wait_drained();
        send_req(REQ_DELETE, 0, '0);
        send_req(REQ_DELETE, list_len - 1, '0);
        send_req(REQ_DELETE, 1, '0);
        send_req(REQ_DELETE, list_len, '0);
        send_req(REQ_DELETE, POS_MAX, '0);
        send_req(REQ_DELETE, POS_MIN, '0);
        send_req(REQ_READ, 0, '0);
    endtask

    task automatic test_full_list();
        int kind;
        while (list_len < CAPACITY) begin
            kind = $urandom_range(REQ_INS_HEAD, REQ_INS_AT);
            send_req(kind[REQ_W-1:0], $urandom_range(0, list_len), rand_value());
        end
        send_req(REQ_INS_HEAD, 0, VAL_MAX);
        send_req(REQ_INS_TAIL, 0, VAL_MIN);
        send_req(REQ_INS_AT, 0, 32'h1);
        send_req(REQ_INS_AT, CAPACITY, 32'h2);
        send_req(REQ_READ, CAPACITY - 1, '0);
        send_req(REQ_READ, CAPACITY, '0);
        send_req(REQ_DELETE, CAPACITY, '0);
        send_req(REQ_DELETE, CAPACITY - 1, '0);
        send_req(REQ_INS_AT, CAPACITY - 1, VAL_NEG1);
        send_req(REQ_READ, CAPACITY - 1, '0);
        no_idle = 1'b1;
        while (list_len > 0) begin
            if ($urandom_range(0, 3) == 0)
                send_req(REQ_READ, $urandom_range(0, list_len - 1), '0);
            send_req(REQ_DELETE, $urandom_range(0, list_len - 1), '0);
            if (list_len == CAPACITY / 2)
                no_idle = 1'b0;
        end
        no_idle = 1'b0;
        send_req(REQ_READ, 0, '0);
    endtask

    task automatic test_random(input int n_items);
        int target;
        int r;
        int p;
        int kind;
        logic [REQ_W-1:0] req;
        logic [POS_W-1:0] raw;
        target = 0;
        for (int n = 0; n < n_items; n++) begin
            if (n % 100 == 0) begin
                case ((n / 100) % 6)
                    1: target = CAPACITY;
                    4: target = 0;
                    default: target = $urandom_range(0, CAPACITY);
                endcase
                no_idle = ((n / 100) % 5 == 2);
                if ((n / 100) % 4 == 3)
                    wait_drained();
            end
            r = $urandom_range(0, 99);
            if (r < 4) begin
                kind = $urandom_range(REQ_BAD_FIRST, REQ_BAD_LAST);
            end else if (r < 28) begin
                kind = REQ_READ;
            end else if (r < ((list_len < target) ? 73 : 43)) begin
                kind = $urandom_range(REQ_INS_HEAD, REQ_INS_AT);
            end else begin
                kind = REQ_DELETE;
            end
            req = kind[REQ_W-1:0];
            if ($urandom_range(0, 99) < 15) begin
                raw = POS_W'($urandom_range(0, 2047));
                p = int'($signed(raw));
            end else begin
                p = int'($urandom_range(0, list_len + 2)) - 1;
            end
            send_req(req, p, rand_value());
        end
        no_idle = 1'b0;
    endtask

    initial begin
        i_rst_n <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_list();
        test_basic_ops();
        test_full_list();
        test_random(800);
        s_tvalid <= 1'b0;
        for (int i = 0; i < 2000 && result_q.size() != 0; i++)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (result_q.size() != 0) begin
            $error("%0d results never arrived", result_q.size());
            fails++;
        end
        $display("%0d requests sent, %0d results checked, peak length %0d",
                 n_sent, n_checked, peak_len);
        $display("%0d inserts refused on a full list, %0d mismatches",
                 n_full_refused, fails);
        if (fails == 0) begin
            $display("indexed_list_insert_delete_top_tb passed");
        end else begin
            $display("indexed_list_insert_delete_top_tb failed");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("indexed_list_insert_delete_top_tb failed");
        $finish;
    end

endmodule
